[rtl/pvs_pkg.sv]
// shared types and constants for the square-root position/velocity shaper
package pvs_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_ACCEL_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_TIME_CONSTANT = 2'd1;

    localparam logic [30:0] ACCEL_RESET = 31'd327680;
    localparam logic [30:0] TAU_RESET   = 31'd32768;
    localparam logic [30:0] T_FLOOR_Q16 = 31'd655;
    localparam logic [19:0] US_PER_S    = 20'd1000000;

    // ceil(2^55 / 15625), exact for (a*dt >> 6) / 15625 over 41-bit dividends
    localparam logic [41:0] DEL_RECIP = 42'd2305843009214;

    // widths of the iterative units, and the stage of the a*dt/1e6 result
    localparam int DIV_P_WN   = 48;  // (|e| << 16) / T
    localparam int DIV_LIM_WN = 51;  // |e| * 1e6 / dt
    localparam int DEL_LAT    = 5;   // stage at which a * dt / 1e6 is ready
    localparam int SQRT_WIN   = 64;

    // stage at which all unit results line up
    localparam int LAT_JOIN  = 2 + DIV_LIM_WN;
    localparam int DLY_SIDE  = LAT_JOIN - 1;
    localparam int DLY_GT    = LAT_JOIN - 4;
    localparam int DLY_Q     = LAT_JOIN - (1 + DIV_P_WN);
    localparam int DLY_DELTA = LAT_JOIN - DEL_LAT;
    localparam int DLY_ROOT  = LAT_JOIN - (6 + SQRT_WIN / 2);
    localparam int PIPE_LAT  = LAT_JOIN + 2;

    localparam int CORR_W  = 40;
    localparam int BOUND_W = 34;
    localparam int DELTA_W = 28;

    typedef struct packed {
        logic                      valid;
        logic signed [CORR_W-1:0]  corr;
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
    } pvs_fin_t;

endpackage

[rtl/pvs_delay.sv]
// stallable delay line that keeps side data aligned with the pipeline
module pvs_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         ce,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sh_reg [N];

    always_ff @(posedge aclk) begin
        if (ce) begin
            sh_reg[0] <= d;
            for (int j = 1; j < N; j++) begin
                sh_reg[j] <= sh_reg[j-1];
            end
        end
    end

    assign q = sh_reg[N-1];

endmodule

[rtl/pvs_div.sv]
// pipelined restoring divider, one quotient bit per stage
module pvs_div #(
    parameter int WN = 48,
    parameter int WD = 31
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [WN-1:0] num,
    input  logic [WD-1:0] den,
    output logic [WN-1:0] quo
);

    logic [WD-1:0] rem_reg [WN];
    logic [WN-1:0] nq_reg  [WN];   // dividend shifts out the top, quotient in the bottom
    logic [WD-1:0] den_reg [WN];

    for (genvar j = 0; j < WN; j++) begin : g_stage
        logic [WD-1:0] rem_in;
        logic [WN-1:0] nq_in;
        logic [WD-1:0] den_in;
        logic [WD:0]   trial;
        logic [WD:0]   diff;
        logic          fit;

        if (j == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign nq_in  = nq_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        assign trial = {rem_in, nq_in[WN-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fit   = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j] <= fit ? diff[WD-1:0] : trial[WD-1:0];
                nq_reg[j]  <= {nq_in[WN-2:0], fit};
                den_reg[j] <= den_in;
            end
        end
    end

    assign quo = nq_reg[WN-1];

endmodule

[rtl/pvs_sqrt.sv]
// pipelined integer square root, one root bit per stage
module pvs_sqrt #(
    parameter int WIN = 64
) (
    input  logic             aclk,
    input  logic             ce,
    input  logic [WIN-1:0]   rad,
    output logic [WIN/2-1:0] root
);

    localparam int H = WIN / 2;

    logic [H+1:0]   rem_reg  [H];
    logic [WIN-1:0] rad_reg  [H];
    logic [H-1:0]   root_reg [H];

    for (genvar j = 0; j < H; j++) begin : g_stage
        logic [H+1:0]   rem_in;
        logic [WIN-1:0] rad_in;
        logic [H-1:0]   root_in;
        logic [H+3:0]   shifted;
        logic [H+3:0]   trial;
        logic [H+3:0]   diff;
        logic           fit;

        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign rad_in  = rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign rad_in  = rad_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign shifted = {rem_in, rad_in[WIN-1 -: 2]};
        assign trial   = {2'b00, root_in, 2'b01};
        assign diff    = shifted - trial;
        assign fit     = (shifted >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j]  <= fit ? diff[H+1:0] : shifted[H+1:0];
                rad_reg[j]  <= {rad_in[WIN-3:0], 2'b00};
                root_reg[j] <= {root_in[H-2:0], fit};
            end
        end
    end

    assign root = root_reg[H-1];

endmodule

[rtl/pvs_out.sv]
// final bound and saturation, output register with skid stage
module pvs_out import pvs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  pvs_fin_t    fin,
    output logic        pipe_ce,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_velocity_setpoint
);

    localparam logic signed [CORR_W-1:0] SAT_MAX = CORR_W'(64'sd2147483647);
    localparam logic signed [CORR_W-1:0] SAT_MIN = CORR_W'(-64'sd2147483648);

    logic signed [CORR_W-1:0] lo_x;
    logic signed [CORR_W-1:0] hi_x;
    logic signed [CORR_W-1:0] bounded;
    logic [31:0]              result_next;

    logic        out_vld_reg;
    logic        skid_vld_reg;
    logic [31:0] out_reg;
    logic [31:0] skid_reg;

    assign lo_x = CORR_W'(fin.lo);
    assign hi_x = CORR_W'(fin.hi);

    always_comb begin
        bounded = fin.corr;
        if (bounded < lo_x) begin
            bounded = lo_x;
        end
        if (bounded > hi_x) begin
            bounded = hi_x;
        end
        if (bounded > SAT_MAX) begin
            bounded = SAT_MAX;
        end
        if (bounded < SAT_MIN) begin
            bounded = SAT_MIN;
        end
        result_next = bounded[31:0];
    end

    // pipeline stops only while the skid stage holds a result
    assign pipe_ce = !skid_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg <= fin.valid;
        end else if (fin.valid) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (!out_vld_reg || m_ready) begin
            out_reg <= result_next;
        end else begin
            skid_reg <= result_next;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_velocity_setpoint = out_reg;

endmodule

[rtl/sqrt_position_velocity_shaper.sv]
// top level of the square-root position/velocity shaper with acceleration limit
//
//  channel  | ports                                               | role
//  ---------+-----------------------------------------------------+------------------------
//  input    | s_valid s_ready s_position_error s_previous_velocity| one axis sample
//           | s_step_time_us                                      |
//  result   | m_valid m_ready m_velocity_setpoint                 | shaped setpoint
//  config   | cfg_valid cfg_ready cfg_index cfg_data              | accel_limit, time_constant
//
// one transaction per cycle is accepted while s_ready is high; the longest path through the
// pipeline is the 51-step |e|*1e6/dt divider plus entry and exit stages.
// reset clears the valid chain, the output/skid flags and the two registers to defaults.
// a stalled result sits in the output register while the pipeline keeps moving; only
// when a second result lands in the skid stage does s_ready drop, and nothing is lost.
module sqrt_position_velocity_shaper import pvs_pkg::*; #(
    parameter int unsigned MIN_DT_US = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_position_error,
    input  logic [31:0] s_previous_velocity,
    input  logic [15:0] s_step_time_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_velocity_setpoint,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    // configuration registers
    logic [30:0] accel_reg;
    logic [30:0] tau_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg <= ACCEL_RESET;
            tau_reg   <= TAU_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACCEL_LIMIT:   accel_reg <= cfg_data;
                CFG_TIME_CONSTANT: tau_reg   <= cfg_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // pipeline advance and valid chain
    logic                  pipe_ce;
    logic [PIPE_LAT-2:0]   vld_reg;

    assign s_ready = pipe_ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_ce) begin
            vld_reg <= {vld_reg[PIPE_LAT-3:0], s_valid};
        end
    end

    // stage 1: magnitude of the error, floored time constant, config products
    logic [31:0] mag_in;
    logic [30:0] tau_floor;
    logic [61:0] at_prod;
    logic [46:0] adt_prod;

    assign mag_in    = s_position_error[31] ? 32'(-s_position_error) : s_position_error;
    assign tau_floor = (tau_reg < T_FLOOR_Q16) ? T_FLOOR_Q16 : tau_reg;
    assign at_prod   = 62'(accel_reg) * 62'(tau_floor);
    assign adt_prod  = 47'(accel_reg) * 47'(s_step_time_us);

    logic        neg1_reg;
    logic [31:0] mag1_reg;
    logic [31:0] vel1_reg;
    logic [15:0] dt1_reg;
    logic        clampen1_reg;
    logic [30:0] tf1_reg;
    logic [61:0] at1_reg;
    logic [46:0] adt1_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            neg1_reg     <= s_position_error[31];
            mag1_reg     <= mag_in;
            vel1_reg     <= s_previous_velocity;
            dt1_reg      <= s_step_time_us;
            clampen1_reg <= (s_step_time_us > 16'(MIN_DT_US));
            tf1_reg      <= tau_floor;
            at1_reg      <= at_prod;
            adt1_reg     <= adt_prod;
        end
    end

    // stage 2: |e|*1e6 for the overshoot clamp, second zone product
    logic [50:0] mag6_prod;
    logic [62:0] zone_prod;

    assign mag6_prod = 51'(mag1_reg) * 51'(US_PER_S);
    assign zone_prod = 63'(at1_reg[47:16]) * 63'(tf1_reg);

    logic [50:0] mag6_2_reg;
    logic [15:0] dt2_reg;
    logic [31:0] mag2_reg;
    logic        huge2_reg;
    logic [62:0] zprod2_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            mag6_2_reg <= mag6_prod;
            dt2_reg    <= dt1_reg;
            mag2_reg   <= mag1_reg;
            huge2_reg  <= |at1_reg[61:48];  // zone beyond any error magnitude
            zprod2_reg <= zone_prod;
        end
    end

    // stage 3: linear zone width
    logic [31:0] mag3_reg;
    logic        huge3_reg;
    logic [46:0] zone3_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            mag3_reg  <= mag2_reg;
            huge3_reg <= huge2_reg;
            zone3_reg <= zprod2_reg[62:16];
        end
    end

    // stage 4: pick square-root or linear law, 2|e| - zone
    logic        gt4_reg;
    logic [32:0] r1_4_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            gt4_reg  <= !huge3_reg && (47'(mag3_reg) > zone3_reg);
            r1_4_reg <= {mag3_reg, 1'b0} - {1'b0, zone3_reg[31:0]};
        end
    end

    // stages 5 and 6: a*(2|e| - zone) as a 31x32 product plus the top bit
    logic [62:0] plo5_reg;
    logic        r1hi5_reg;
    logic [63:0] rad6_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            plo5_reg  <= 63'(accel_reg) * 63'(r1_4_reg[31:0]);
            r1hi5_reg <= r1_4_reg[32];
            rad6_reg  <= 64'(plo5_reg) + (r1hi5_reg ? {1'b0, accel_reg, 32'b0} : 64'd0);
        end
    end

    // stages 2 to 5: a*dt/1e6 as (a*dt >> 6) / 15625 by reciprocal multiply,
    // the 41x42 product split at bit 21 into four partial products
    logic [40:0] adt_sh;

    assign adt_sh = adt1_reg[46:6];

    logic [41:0] pll2_reg;
    logic [41:0] plh2_reg;
    logic [40:0] phl2_reg;
    logic [40:0] phh2_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            pll2_reg <= 42'(adt_sh[20:0]) * 42'(DEL_RECIP[20:0]);
            plh2_reg <= 42'(adt_sh[20:0]) * 42'(DEL_RECIP[41:21]);
            phl2_reg <= 41'(adt_sh[40:21]) * 41'(DEL_RECIP[20:0]);
            phh2_reg <= 41'(adt_sh[40:21]) * 41'(DEL_RECIP[41:21]);
        end
    end

    logic [42:0] mid3_reg;
    logic [41:0] pll3_reg;
    logic [40:0] phh3_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            mid3_reg <= 43'(plh2_reg) + 43'(phl2_reg);
            pll3_reg <= pll2_reg;
            phh3_reg <= phh2_reg;
        end
    end

    // low part keeps its carry into bit 42, high part counts in units of 2^42
    logic [42:0] slo4_reg;
    logic [41:0] shi4_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            slo4_reg <= 43'(pll3_reg) + 43'({mid3_reg[20:0], 21'b0});
            shi4_reg <= 42'(phh3_reg) + 42'(mid3_reg[42:21]);
        end
    end

    // product >> 55 is (high + carry) >> 13
    logic [41:0]        dsum;
    logic [DELTA_W-1:0] delta5_reg;

    assign dsum = shi4_reg + 42'(slo4_reg[42]);

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            delta5_reg <= dsum[DELTA_W+12:13];
        end
    end

    // iterative units
    logic [SQRT_WIN/2-1:0] root_raw;
    logic [DIV_P_WN-1:0]   q_raw;
    logic [DIV_LIM_WN-1:0] lim_raw;

    pvs_sqrt #(.WIN(SQRT_WIN)) u_sqrt (
        .aclk (aclk),
        .ce   (pipe_ce),
        .rad  (rad6_reg),
        .root (root_raw)
    );

    pvs_div #(.WN(DIV_P_WN), .WD(31)) u_div_p (
        .aclk (aclk),
        .ce   (pipe_ce),
        .num  ({mag1_reg, 16'b0}),
        .den  (tf1_reg),
        .quo  (q_raw)
    );

    pvs_div #(.WN(DIV_LIM_WN), .WD(16)) u_div_lim (
        .aclk (aclk),
        .ce   (pipe_ce),
        .num  (mag6_2_reg),
        .den  (dt2_reg),
        .quo  (lim_raw)
    );

    // alignment of everything to the join stage
    logic                  neg_d;
    logic [31:0]           vel_d;
    logic                  clampen_d;
    logic                  gt_d;
    logic [37:0]           q_d;
    logic [DELTA_W-1:0]    delta_d;
    logic [SQRT_WIN/2-1:0] root_d;

    pvs_delay #(.W(34), .N(DLY_SIDE)) u_dly_side (
        .aclk (aclk),
        .ce   (pipe_ce),
        .d    ({neg1_reg, vel1_reg, clampen1_reg}),
        .q    ({neg_d, vel_d, clampen_d})
    );

    pvs_delay #(.W(1), .N(DLY_GT)) u_dly_gt (
        .aclk (aclk),
        .ce   (pipe_ce),
        .d    (gt4_reg),
        .q    (gt_d)
    );

    // linear-law quotient never exceeds 2^47/655, so 38 bits hold it
    pvs_delay #(.W(38), .N(DLY_Q)) u_dly_q (
        .aclk (aclk),
        .ce   (pipe_ce),
        .d    (q_raw[37:0]),
        .q    (q_d)
    );

    // a*dt/1e6 stays below 2^28
    pvs_delay #(.W(DELTA_W), .N(DLY_DELTA)) u_dly_delta (
        .aclk (aclk),
        .ce   (pipe_ce),
        .d    (delta5_reg),
        .q    (delta_d)
    );

    pvs_delay #(.W(SQRT_WIN/2), .N(DLY_ROOT)) u_dly_root (
        .aclk (aclk),
        .ce   (pipe_ce),
        .d    (root_raw),
        .q    (root_d)
    );

    // join stage: signed correction and acceleration window
    logic [37:0]               mag_sel;
    logic signed [CORR_W-1:0]  corr_mag;
    logic signed [BOUND_W-1:0] vel_x;
    logic signed [BOUND_W-1:0] delta_x;

    assign mag_sel  = gt_d ? 38'(root_d) : q_d;
    assign corr_mag = signed'(CORR_W'(mag_sel));
    assign vel_x    = BOUND_W'(signed'(vel_d));
    assign delta_x  = signed'(BOUND_W'(delta_d));

    logic signed [CORR_W-1:0]  c_j_reg;
    logic signed [BOUND_W-1:0] lo_j_reg;
    logic signed [BOUND_W-1:0] hi_j_reg;
    logic [DIV_LIM_WN-1:0]     lim_j_reg;
    logic                      clampen_j_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            c_j_reg       <= neg_d ? -corr_mag : corr_mag;
            lo_j_reg      <= vel_x - delta_x;
            hi_j_reg      <= vel_x + delta_x;
            lim_j_reg     <= lim_raw;
            clampen_j_reg <= clampen_d;
        end
    end

    // overshoot clamp to +-|e|/dt when the step is long enough
    logic                     lim_big;
    logic signed [CORR_W-1:0] lim_pos;
    logic signed [CORR_W-1:0] lim_neg;
    logic signed [CORR_W-1:0] c_next;

    assign lim_big = |lim_j_reg[DIV_LIM_WN-1:CORR_W-1];
    assign lim_pos = signed'({1'b0, lim_j_reg[CORR_W-2:0]});
    assign lim_neg = -lim_pos;

    always_comb begin
        c_next = c_j_reg;
        if (clampen_j_reg && !lim_big) begin
            if (c_next > lim_pos) begin
                c_next = lim_pos;
            end
            if (c_next < lim_neg) begin
                c_next = lim_neg;
            end
        end
    end

    // last stage of the valid chain travels with the bounded correction
    pvs_fin_t fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_reg.valid <= 1'b0;
        end else if (pipe_ce) begin
            fin_reg.valid <= vld_reg[PIPE_LAT-2];
            fin_reg.corr  <= c_next;
            fin_reg.lo    <= lo_j_reg;
            fin_reg.hi    <= hi_j_reg;
        end
    end

    // acceleration bound, saturation and output buffering
    pvs_out u_out (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .fin                 (fin_reg),
        .pipe_ce             (pipe_ce),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_velocity_setpoint (m_velocity_setpoint)
    );

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the square-root position/velocity shaper
`timescale 1ns / 1ps

module tb_top import pvs_pkg::*; ();

    localparam int MIN_DT        = 10;
    localparam int LATENCY       = 56;
    localparam int RANDOM_ITEMS  = 600;
    localparam longint CYCLE_CAP = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_position_error = '0;
    logic [31:0] s_previous_velocity = '0;
    logic [15:0] s_step_time_us = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_velocity_setpoint;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    sqrt_position_velocity_shaper #(.MIN_DT_US(MIN_DT)) i_dut (.*);

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor copy of the two registers
    logic [30:0] accel_q;
    logic [30:0] tau_q;

    logic [31:0] setpoint_q[$];
    int          fail_count = 0;
    int          checked = 0;
    longint      cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    typedef struct {
        logic [31:0] err;
        logic [31:0] vel;
        logic [15:0] dt;
        bit          known;
        logic [31:0] setpoint;
    } stim_row_t;

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // shaped velocity for one sample under the current registers
    function automatic logic [31:0] shaped_velocity(logic [31:0] err_raw, logic [31:0] vel_raw,
                                                    logic [15:0] dt_raw);
        longint          e;
        longint          v;
        longint unsigned a;
        longint unsigned t;
        longint unsigned dt;
        longint unsigned mag;
        longint unsigned zone;
        longint unsigned x;
        longint unsigned delta;
        longint          c;
        longint          lim;
        e = longint'(signed'(err_raw));
        v = longint'(signed'(vel_raw));
        dt = dt_raw;
        a = accel_q;
        t = (tau_q < T_FLOOR_Q16) ? T_FLOOR_Q16 : tau_q;
        mag = (e < 0) ? -e : e;
        x = (a * t) >> 16;
        // zone too wide for any error: linear law everywhere
        if (x >= 64'h1_0000_0000) zone = 64'h2_0000_0000;
        else zone = (x * t) >> 16;
        if (mag > zone) begin
            c = int_sqrt(a * (2 * mag - zone));
            if (e < 0) c = -c;
        end else begin
            c = (mag << 16) / t;
            if (e < 0) c = -c;
        end
        // overshoot clamp only above the short step
        if (dt > MIN_DT) begin
            lim = (mag * 1000000) / dt;
            if (c > lim) c = lim;
            if (c < -lim) c = -lim;
        end
        delta = (a * dt) / 1000000;
        if (c < v - longint'(delta)) c = v - longint'(delta);
        if (c > v + longint'(delta)) c = v + longint'(delta);
        if (c > 64'sd2147483647) c = 64'sd2147483647;
        if (c < -64'sd2147483648) c = -64'sd2147483648;
        return c[31:0];
    endfunction

    // result side: random stall, compare against oldest expectation
    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("sqrt_position_velocity_shaper regression: fail");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (setpoint_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_velocity_setpoint);
                fail_count <= fail_count + 1;
            end else begin
                if (m_velocity_setpoint !== setpoint_q[0]) begin
                    $display("%0t: velocity_setpoint expected %h actual %h", $time,
                             setpoint_q[0], m_velocity_setpoint);
                    fail_count <= fail_count + 1;
                end
                void'(setpoint_q.pop_front());
                checked <= checked + 1;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ACCEL_LIMIT) accel_q = value;
        else if (idx == CFG_TIME_CONSTANT) tau_q = value;
        @(negedge aclk);
    endtask

    // one input transaction, with random idle before it; queue the prediction at acceptance
    task automatic send_sample(logic [31:0] err, logic [31:0] vel, logic [15:0] dt,
                               bit known, logic [31:0] typed);
        logic [31:0] predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_position_error <= err;
        s_previous_velocity <= vel;
        s_step_time_us <= dt;
        predicted = shaped_velocity(err, vel, dt);
        if (known && typed !== predicted)
            $display("%0t: table row expected %h but predictor gives %h", $time, typed, predicted);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        setpoint_q.push_back(known ? typed : predicted);
        @(negedge aclk);
    endtask

    // drain everything, then let the pipe empty
    task automatic settle();
        s_valid <= 1'b0;
        while (setpoint_q.size() != 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(4000) - 2000;
            1: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            2: return {1'b0, 31'h7FFF_FFFF} - $urandom_range(3);
            3: return 32'h8000_0000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_dt();
        case ($urandom_range(4))
            0: return $urandom_range(MIN_DT + 1);
            1: return 16'hFFFF;
            default: return $urandom_range(20000);
        endcase
    endfunction

    stim_row_t table_rows[$];
    int phase_idle[4] = '{0, 61, 0, 12};
    int phase_stall[4] = '{0, 0, 61, 12};
    logic [30:0] accel_set[5] = '{31'd327680, 31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd5000000};
    logic [30:0] tau_set[5] = '{31'd32768, 31'd0, 31'd1, 31'h7FFF_FFFF, 31'd655};

    initial begin
        accel_q = ACCEL_RESET;
        tau_q = TAU_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows: zero step passes previous velocity through, zero error
        // with a zero velocity stays zero, the rest go through the predictor
        table_rows = '{
            '{32'h0, 32'h0, 16'd0, 1, 32'h0},
            '{32'h7FFF_FFFF, 32'h1234_5678, 16'd0, 1, 32'h1234_5678},
            '{32'h8000_0000, 32'h8000_0000, 16'd0, 1, 32'h8000_0000},
            '{32'h0, 32'h0, 16'hFFFF, 1, 32'h0},
            '{32'h0001_0000, 32'h0, 16'd1000, 0, 0},
            '{32'hFFFF_0000, 32'h0, 16'd1000, 0, 0},
            '{32'h7FFF_FFFF, 32'h0, 16'hFFFF, 0, 0},
            '{32'h8000_0000, 32'h0, 16'hFFFF, 0, 0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 0, 0},
            '{32'h8000_0000, 32'h8000_0000, 16'hFFFF, 0, 0},
            '{32'h0100_0000, 32'h0, 16'd10, 0, 0},
            '{32'h0100_0000, 32'h0, 16'd11, 0, 0},
            '{32'h0000_1000, 32'h0, 16'd5, 0, 0},
            '{32'h0020_0000, 32'h0010_0000, 16'd20000, 0, 0},
            '{32'hFFE0_0000, 32'hFFF0_0000, 16'd20000, 0, 0},
            '{32'h0000_0001, 32'h0, 16'd1, 0, 0},
            '{32'hFFFF_FFFF, 32'h0, 16'd65535, 0, 0}
        };
        // directed part under reset values, then under extreme settings
        foreach (table_rows[i])
            send_sample(table_rows[i].err, table_rows[i].vel, table_rows[i].dt,
                        table_rows[i].known, table_rows[i].setpoint);
        settle();
        write_reg(CFG_ACCEL_LIMIT, 31'd0);
        write_reg(CFG_TIME_CONSTANT, 31'd0);
        // zero acceleration: the output is always the previous velocity
        send_sample(32'h0100_0000, 32'h0000_5555, 16'd500, 1, 32'h0000_5555);
        send_sample(32'h8000_0000, 32'hDEAD_BEEF, 16'hFFFF, 1, 32'hDEAD_BEEF);
        settle();
        // out-of-range index is ignored by the block
        write_reg(2'd3, 31'h1234_5678);
        send_sample(32'h7FFF_FFFF, 32'h0000_0007, 16'd100, 1, 32'h0000_0007);
        settle();

        // random part, walking through register settings and idle phases
        for (int p = 0; p < 20; p++) begin
            write_reg(CFG_ACCEL_LIMIT, ($urandom_range(2) == 0) ? 31'($urandom)
                                                                 : accel_set[p % 5]);
            write_reg(CFG_TIME_CONSTANT, ($urandom_range(2) == 0) ? 31'($urandom_range(200000))
                                                                   : tau_set[(p / 5 + p) % 5]);
            send_idle_pct = phase_idle[p % 4];
            recv_stall_pct = phase_stall[p % 4];
            for (int k = 0; k < RANDOM_ITEMS / 20; k++)
                send_sample(rand_word(), rand_word(), rand_dt(), 0, 0);
            settle();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        settle();

        $display("checked %0d setpoints across 20 register settings and four idle mixes", checked);
        if (fail_count == 0) begin
            $display("sqrt_position_velocity_shaper regression: pass");
        end else begin
            $display("sqrt_position_velocity_shaper regression: fail");
        end
        $finish;
    end
endmodule
